FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every active clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: invariant");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: hdl/pida_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pida_pkg;

   localparam int POS_W    = 6;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 2;

   typedef enum logic [1:0] {
      CMD_TRAVERSE = 2'd0,
      CMD_INSERT   = 2'd1,
      CMD_DELETE   = 2'd2,
      CMD_UPDATE   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK    = 2'd0,
      STS_OOB   = 2'd1,
      STS_FULL  = 2'd2,
      STS_EMPTY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_TRAV,
      S_INS,
      S_DEL
   } state_type;

endpackage

`default_nettype wire

FILE: hdl/positional_insert_delete_array.sv
// positional_insert_delete_array: packed array of signed 32-bit words with a
// live count, held in one synchronous single-read single-write memory.
// commands come in on the req_ ports and are taken at a rising edge where
// start is high and busy is low; results leave on the rsp_ ports, one beat
// per cycle marked by rsp_strobe, and the receiver cannot stall them.
// command handling, with p = requested position:
//   errors, update, insert at the end: one registered result beat, no busy
//   traverse: busy while the words are read in order, one result beat per
//     cycle (an empty array answers with a single status beat, no busy)
//   insert inside the array: busy while the words from p up move up
//   delete: busy while the word at p is read and the words above move down
// every word moved by a shift passes through the memory's single read
// port and single write port.
// reset clears the count and the control state only; the memory contents
// are not cleared and are never read before they were written.
// busy stays high while a command is at work; the last result beat of a
// command may overlap the first cycle in which a new command is taken.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module positional_insert_delete_array
   import pida_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // command channel
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [1:0]                 req_command,
   input  wire logic [POS_W-1:0]           req_position,
   input  wire logic signed [WORD_W-1:0]   req_value,
   // result channel
   output logic                            rsp_strobe,
   output logic [STATUS_W-1:0]             rsp_status,
   output logic [POS_W-1:0]                rsp_index,
   output logic signed [WORD_W-1:0]        rsp_word,
   output logic [POS_W-1:0]                rsp_stored_count,
   output logic                            rsp_last
);

   // address width for the memory, count width able to hold DEPTH itself
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   // common width to compare a requested position against the count
   localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

   // ---------------------------------------------------------------------
   // word store: one write and one registered read per cycle
   // ---------------------------------------------------------------------
   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rdata_ff;

   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [WORD_W-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // ---------------------------------------------------------------------
   // control and result registers
   // ---------------------------------------------------------------------
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;          // walking read or write pointer
   logic [CNT_W-1:0]  pos_ff, pos_in;          // target position of an edit
   logic [WORD_W-1:0] val_ff, val_in;          // insert value or removed word
   logic              pipe_vld_ff, pipe_vld_in; // a read was issued last cycle
   logic [ADDR_W-1:0] pipe_addr_ff, pipe_addr_in;

   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]    rsp_index_ff, rsp_index_in;
   logic [WORD_W-1:0]   rsp_word_ff, rsp_word_in;
   logic [POS_W-1:0]    rsp_count_ff, rsp_count_in;
   logic                rsp_last_ff, rsp_last_in;

   logic              accept;
   logic [CMP_W-1:0]  pos_cmp;
   logic [CMP_W-1:0]  cnt_cmp;
   logic              is_full;
   logic [CNT_W-1:0]  ptr_dec;
   logic              trav_last;

   assign busy    = (state_ff != S_IDLE);
   assign accept  = start && !busy;
   assign pos_cmp = CMP_W'(req_position);
   assign cnt_cmp = CMP_W'(count_ff);
   assign is_full = (count_ff == CNT_W'(DEPTH));
   assign ptr_dec = ptr_ff - CNT_W'(1);
   // the beat coming out of the read register is the final stored word
   assign trav_last = ((CNT_W'(pipe_addr_ff) + CNT_W'(1)) == count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         pipe_vld_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pipe_vld_ff   <= pipe_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      pipe_addr_ff  <= pipe_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // ---------------------------------------------------------------------
   // next state, memory access and result beat
   // ---------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      pipe_vld_in   = 1'b0;
      pipe_addr_in  = pipe_addr_ff;

      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;

      rd_en   = 1'b0;
      rd_addr = ptr_ff[ADDR_W-1:0];
      wr_en   = 1'b0;
      wr_addr = req_position[ADDR_W-1:0];
      wr_data = req_value;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // error beats share this shape
               rsp_strobe_in = 1'b1;
               rsp_index_in  = req_position;
               rsp_word_in   = '0;
               rsp_count_in  = POS_W'(count_ff);
               rsp_last_in   = 1'b1;
               unique case (cmd_type'(req_command))
                  CMD_TRAVERSE: begin
                     if (count_ff == '0) begin
                        rsp_status_in = STS_EMPTY;
                        rsp_index_in  = '0;
                     end else begin
                        rsp_strobe_in = 1'b0;
                        ptr_in        = '0;
                        state_in      = S_TRAV;
                     end
                  end
                  CMD_INSERT: begin
                     if (pos_cmp > cnt_cmp) begin
                        rsp_status_in = STS_OOB;
                     end else if (is_full) begin
                        rsp_status_in = STS_FULL;
                     end else if (pos_cmp == cnt_cmp) begin
                        // append needs no shift
                        wr_en         = 1'b1;
                        count_in      = count_ff + CNT_W'(1);
                        rsp_status_in = STS_OK;
                        rsp_word_in   = req_value;
                        rsp_count_in  = POS_W'(count_in);
                     end else begin
                        rsp_strobe_in = 1'b0;
                        ptr_in        = count_ff;
                        pos_in        = CNT_W'(req_position);
                        val_in        = req_value;
                        state_in      = S_INS;
                     end
                  end
                  CMD_DELETE: begin
                     if (pos_cmp >= cnt_cmp) begin
                        rsp_status_in = STS_OOB;
                     end else begin
                        rsp_strobe_in = 1'b0;
                        ptr_in        = CNT_W'(req_position);
                        pos_in        = CNT_W'(req_position);
                        state_in      = S_DEL;
                     end
                  end
                  CMD_UPDATE: begin
                     if (pos_cmp >= cnt_cmp) begin
                        rsp_status_in = STS_OOB;
                     end else begin
                        wr_en         = 1'b1;
                        rsp_status_in = STS_OK;
                        rsp_word_in   = req_value;
                     end
                  end
                  default: begin
                     rsp_status_in = STS_OOB;
                  end
               endcase
            end
         end

         S_TRAV: begin
            // issue reads in order; each beat leaves through the read register and the result registers
            if (ptr_ff < count_ff) begin
               rd_en        = 1'b1;
               rd_addr      = ptr_ff[ADDR_W-1:0];
               pipe_vld_in  = 1'b1;
               pipe_addr_in = ptr_ff[ADDR_W-1:0];
               ptr_in       = ptr_ff + CNT_W'(1);
            end
            if (pipe_vld_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = STS_OK;
               rsp_index_in  = POS_W'(pipe_addr_ff);
               rsp_word_in   = rdata_ff;
               rsp_count_in  = POS_W'(count_ff);
               rsp_last_in   = trav_last;
               if (trav_last) begin
                  state_in = S_IDLE;
               end
            end
         end

         S_INS: begin
            // walk down from the top: read i-1, write it to i next cycle
            if (ptr_ff > pos_ff) begin
               rd_en        = 1'b1;
               rd_addr      = ptr_dec[ADDR_W-1:0];
               pipe_vld_in  = 1'b1;
               pipe_addr_in = ptr_dec[ADDR_W-1:0];
               ptr_in       = ptr_dec;
            end
            if (pipe_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = pipe_addr_ff + ADDR_W'(1);
               wr_data = rdata_ff;
            end else if (ptr_ff == pos_ff) begin
               // gap is open, drop the new word in
               wr_en         = 1'b1;
               wr_addr       = pos_ff[ADDR_W-1:0];
               wr_data       = val_ff;
               count_in      = count_ff + CNT_W'(1);
               rsp_strobe_in = 1'b1;
               rsp_status_in = STS_OK;
               rsp_index_in  = POS_W'(pos_ff);
               rsp_word_in   = val_ff;
               rsp_count_in  = POS_W'(count_in);
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         S_DEL: begin
            // walk up: the first read is the removed word, the rest move down
            if (ptr_ff < count_ff) begin
               rd_en        = 1'b1;
               rd_addr      = ptr_ff[ADDR_W-1:0];
               pipe_vld_in  = 1'b1;
               pipe_addr_in = ptr_ff[ADDR_W-1:0];
               ptr_in       = ptr_ff + CNT_W'(1);
            end
            if (pipe_vld_ff) begin
               if (CNT_W'(pipe_addr_ff) == pos_ff) begin
                  val_in = rdata_ff;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = pipe_addr_ff - ADDR_W'(1);
                  wr_data = rdata_ff;
               end
            end else if (ptr_ff == count_ff) begin
               count_in      = count_ff - CNT_W'(1);
               rsp_strobe_in = 1'b1;
               rsp_status_in = STS_OK;
               rsp_index_in  = POS_W'(pos_ff);
               rsp_word_in   = val_ff;
               rsp_count_in  = POS_W'(count_in);
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_index        = rsp_index_ff;
   assign rsp_word         = rsp_word_ff;
   assign rsp_stored_count = rsp_count_ff;
   assign rsp_last         = rsp_last_ff;

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
   // the count never runs past the capacity
   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH))
   // a taken command either answers at once or keeps the block busy
   `ASSERT_NEXT(a_accept_progress, clock, reset, accept, busy || rsp_strobe)
   // the store is never written while nothing is at work
   `ASSERT_IMPLIES(a_idle_no_write, clock, reset, !busy && !accept, !wr_en)
   // an error or empty beat always closes its command
   `ASSERT_IMPLIES(a_error_is_last, clock, reset,
      rsp_strobe && (rsp_status != STS_OK), rsp_last)

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import pida_pkg::*;

   localparam int DEPTH       = 32;
   // cycles with no command taken and no result beat before we give up
   localparam int QUIET_LIMIT = 2000;
   // quiet tail after draining, longer than a full traverse holds the block
   localparam int SETTLE      = 3 * DEPTH;

   // one expected result beat
   typedef struct {
      status_type        status;
      logic [POS_W-1:0]  index;
      logic [WORD_W-1:0] word;
      logic [POS_W-1:0]  stored_count;
      logic              is_last;
   } array_beat_type;

   logic                     clock;
   logic                     reset        = 1'b1;
   logic                     start        = 1'b0;
   logic [1:0]               req_command  = CMD_TRAVERSE;
   logic [POS_W-1:0]         req_position = '0;
   logic signed [WORD_W-1:0] req_value    = '0;
   logic                     busy;
   logic                     rsp_strobe;
   logic [STATUS_W-1:0]      rsp_status;
   logic [POS_W-1:0]         rsp_index;
   logic signed [WORD_W-1:0] rsp_word;
   logic [POS_W-1:0]         rsp_stored_count;
   logic                     rsp_last;

   // shadow copy of the array contents and fill level
   logic [WORD_W-1:0] shadow_words [DEPTH];
   int                shadow_count;

   // beats still owed by the block, oldest first
   array_beat_type    pending_beats [$];
   array_beat_type    expected_beat;

   int                mismatches   = 0;
   int                quiet_cycles = 0;
   bit                back_to_back = 1'b0;
   // random edits drift upward while set, downward while clear
   bit                growing      = 1'b1;

   positional_insert_delete_array #(
      .DEPTH(DEPTH)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_index       (rsp_index),
      .rsp_word        (rsp_word),
      .rsp_stored_count(rsp_stored_count),
      .rsp_last        (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // queue one expected beat, stamped with the current fill level
   function automatic void push_beat(status_type st, logic [POS_W-1:0] idx,
                                     logic [WORD_W-1:0] w, logic lst);
      array_beat_type b;
      b.status       = st;
      b.index        = idx;
      b.word         = w;
      b.stored_count = POS_W'(shadow_count);
      b.is_last      = lst;
      pending_beats.push_back(b);
   endfunction

   // apply one accepted command to the shadow array and queue its beats
   function automatic void predict_command(cmd_type op, logic [POS_W-1:0] pos,
                                           logic [WORD_W-1:0] val);
      int               i;
      logic [WORD_W-1:0] removed;
      case (op)
         CMD_TRAVERSE: begin
            if (shadow_count == 0) begin
               // empty array answers with a single status beat
               push_beat(STS_EMPTY, '0, '0, 1'b1);
            end else begin
               for (i = 0; i < shadow_count; i++)
                  push_beat(STS_OK, POS_W'(i), shadow_words[i], i == shadow_count - 1);
            end
         end
         CMD_INSERT: begin
            // range check wins over the full check
            if (pos > shadow_count) begin
               push_beat(STS_OOB, pos, '0, 1'b1);
            end else if (shadow_count >= DEPTH) begin
               push_beat(STS_FULL, pos, '0, 1'b1);
            end else begin
               for (i = shadow_count; i > pos; i--)
                  shadow_words[i] = shadow_words[i-1];
               shadow_words[pos] = val;
               shadow_count++;
               push_beat(STS_OK, pos, val, 1'b1);
            end
         end
         CMD_DELETE: begin
            if (pos >= shadow_count) begin
               push_beat(STS_OOB, pos, '0, 1'b1);
            end else begin
               removed = shadow_words[pos];
               for (i = pos; i + 1 < shadow_count; i++)
                  shadow_words[i] = shadow_words[i+1];
               shadow_count--;
               push_beat(STS_OK, pos, removed, 1'b1);
            end
         end
         default: begin
            if (pos >= shadow_count) begin
               push_beat(STS_OOB, pos, '0, 1'b1);
            end else begin
               shadow_words[pos] = val;
               push_beat(STS_OK, pos, val, 1'b1);
            end
         end
      endcase
   endfunction

   // mostly random words, with the sign and all-ones corners mixed in
   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 15))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   // hand one command to the block; returns on the edge that takes it,
   // leaving start high so a back-to-back command needs no extra edge
   task automatic send_cmd(input cmd_type op, input logic [POS_W-1:0] pos,
                           input logic [WORD_W-1:0] val);
      int gap;
      gap = back_to_back ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start        <= 1'b1;
      req_command  <= op;
      req_position <= pos;
      req_value    <= val;
      @(posedge clock);
      // busy is sampled before this edge updates it
      while (busy !== 1'b0) @(posedge clock);
      predict_command(op, pos, val);
   endtask

   // stop issuing and let every owed beat come back, then a quiet tail
   task automatic wait_drained();
      start <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // requests against an empty array: every one is rejected
   task automatic test_empty_array();
      back_to_back = 1'b0;
      send_cmd(CMD_TRAVERSE, 6'd0, 32'h0);
      send_cmd(CMD_DELETE, 6'd0, 32'h0);
      send_cmd(CMD_UPDATE, 6'd0, 32'h1234_5678);
      send_cmd(CMD_INSERT, 6'd1, 32'hDEAD_BEEF);
      send_cmd(CMD_INSERT, 6'd63, 32'hFFFF_FFFF);
      send_cmd(CMD_DELETE, 6'd63, 32'h0);
      send_cmd(CMD_UPDATE, 6'd32, 32'h8000_0000);
   endtask

   // insert at head, tail and middle, then edit and shrink back to empty
   task automatic test_basic_edits();
      back_to_back = 1'b0;
      send_cmd(CMD_INSERT, 6'd0, 32'h7FFF_FFFF);
      send_cmd(CMD_INSERT, 6'd0, 32'h8000_0000);
      send_cmd(CMD_INSERT, 6'd2, 32'h0000_0000);
      send_cmd(CMD_INSERT, 6'd1, 32'hFFFF_FFFF);
      send_cmd(CMD_TRAVERSE, 6'd0, 32'h0);
      send_cmd(CMD_UPDATE, 6'd3, 32'h1234_5678);
      // one past the end is out of range for update and delete
      send_cmd(CMD_UPDATE, 6'd4, 32'h5555_AAAA);
      send_cmd(CMD_DELETE, 6'd4, 32'h0);
      send_cmd(CMD_INSERT, 6'd5, 32'h0F0F_0F0F);
      back_to_back = 1'b1;
      send_cmd(CMD_DELETE, 6'd1, 32'h0);
      send_cmd(CMD_DELETE, 6'd2, 32'h0);
      send_cmd(CMD_DELETE, 6'd0, 32'h0);
      send_cmd(CMD_TRAVERSE, 6'd0, 32'h0);
      send_cmd(CMD_DELETE, 6'd0, 32'h0);
      send_cmd(CMD_TRAVERSE, 6'd0, 32'h0);
   endtask

   // random inserts until full, then the full and range corners at the top
   task automatic test_fill_to_full();
      int k;
      k = 0;
      while (shadow_count < DEPTH) begin
         if (k % 8 == 0) back_to_back = ($urandom_range(0, 2) == 0);
         send_cmd(CMD_INSERT, POS_W'($urandom_range(0, shadow_count)), pick_word());
         k++;
      end
      back_to_back = 1'b0;
      send_cmd(CMD_INSERT, POS_W'(DEPTH), 32'h1111_1111);
      send_cmd(CMD_INSERT, 6'd0, 32'h2222_2222);
      // beyond count on a full array reports out of range, not full
      send_cmd(CMD_INSERT, POS_W'(DEPTH + 1), 32'h3333_3333);
      send_cmd(CMD_INSERT, 6'd63, 32'h4444_4444);
      send_cmd(CMD_TRAVERSE, 6'd0, 32'h0);
      send_cmd(CMD_UPDATE, POS_W'(DEPTH - 1), 32'h8000_0001);
      back_to_back = 1'b1;
      send_cmd(CMD_TRAVERSE, 6'd0, 32'h0);
      send_cmd(CMD_DELETE, POS_W'(DEPTH - 1), 32'h0);
      send_cmd(CMD_UPDATE, POS_W'(DEPTH - 1), 32'h7FFF_FFFE);
      send_cmd(CMD_DELETE, 6'd0, 32'h0);
   endtask

   // mostly well-formed edits that wander the fill level up and down,
   // some traverses, and a slice of out-of-range noise
   task automatic test_random_mix(input int n_items);
      int      k;
      int      pick;
      int      edit;
      cmd_type op;
      for (k = 0; k < n_items; k++) begin
         if (k % 20 == 0) back_to_back = ($urandom_range(0, 2) == 0);
         if (shadow_count == DEPTH) growing = 1'b0;
         if (shadow_count == 0)     growing = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            send_cmd(CMD_TRAVERSE, POS_W'($urandom_range(0, 63)), pick_word());
         end else if (pick < 20) begin
            // noise: any edit at any position the field allows
            case ($urandom_range(0, 2))
               0:       op = CMD_INSERT;
               1:       op = CMD_DELETE;
               default: op = CMD_UPDATE;
            endcase
            send_cmd(op, POS_W'($urandom_range(0, 63)), pick_word());
         end else if (shadow_count == 0) begin
            send_cmd(CMD_INSERT, 6'd0, pick_word());
         end else begin
            edit = $urandom_range(0, 99);
            if (edit < 25) begin
               send_cmd(CMD_UPDATE, POS_W'($urandom_range(0, shadow_count - 1)),
                        pick_word());
            end else if (edit < (growing ? 80 : 45)) begin
               send_cmd(CMD_INSERT, POS_W'($urandom_range(0, shadow_count)), pick_word());
            end else begin
               send_cmd(CMD_DELETE, POS_W'($urandom_range(0, shadow_count - 1)),
                        pick_word());
            end
         end
      end
   endtask

   // result checker: every strobe must match the oldest owed beat
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_beats.size() == 0) begin
            $error("unexpected result beat: index %0d word 0x%08h", rsp_index, rsp_word);
            mismatches++;
         end else begin
            expected_beat = pending_beats.pop_front();
            if (rsp_status !== expected_beat.status) begin
               $error("rsp_status: expected %0d, got %0d", expected_beat.status, rsp_status);
               mismatches++;
            end
            if (rsp_index !== expected_beat.index) begin
               $error("rsp_index: expected %0d, got %0d", expected_beat.index, rsp_index);
               mismatches++;
            end
            if (rsp_word !== expected_beat.word) begin
               $error("rsp_word: expected 0x%08h, got 0x%08h", expected_beat.word, rsp_word);
               mismatches++;
            end
            if (rsp_stored_count !== expected_beat.stored_count) begin
               $error("rsp_stored_count: expected %0d, got %0d",
                      expected_beat.stored_count, rsp_stored_count);
               mismatches++;
            end
            if (rsp_last !== expected_beat.is_last) begin
               $error("rsp_last: expected %0d, got %0d", expected_beat.is_last, rsp_last);
               mismatches++;
            end
         end
      end
   end

   // watchdog: too long with no command taken and no beat out means a hang
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_strobe === 1'b1)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      shadow_count = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_empty_array();
      test_basic_edits();
      test_fill_to_full();
      test_random_mix(150);
      wait_drained();
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
